### rtl/core/midpoint_circle_rasterizer_defines.svh
// Assertion macros for the rasterizer RTL.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define MCR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MCR_ASSERT_DEF(label, prop) `MCR_ASSERT(label, clk_i, rst_ni, prop)
`else
`define MCR_ASSERT(label, clk, rst_n, prop)
`define MCR_ASSERT_DEF(label, prop)
`endif

`endif

### rtl/core/mcr_pkg.sv
package mcr_pkg;

  localparam int CoordBits    = 13;
  localparam int PixelBits    = CoordBits + 1;
  localparam int DecisionBits = 17;
  localparam int FrameBits    = 13;
  localparam int RadiusBits   = 12;
  localparam int ColorBits    = 32;
  localparam int CfgDataBits  = 32;
  localparam int CfgAddrBits  = 3;
  localparam int PointsPerRun = 8;
  localparam int PointIdxBits = $clog2(PointsPerRun);

  localparam logic [FrameBits-1:0] FrameWidthReset  = FrameBits'(1024);
  localparam logic [FrameBits-1:0] FrameHeightReset = FrameBits'(768);

  localparam logic [DecisionBits-1:0] DecisionInit = DecisionBits'(3);
  localparam logic [DecisionBits-1:0] StepDiag     = DecisionBits'(10);
  localparam logic [DecisionBits-1:0] StepAxis     = DecisionBits'(6);

  typedef enum logic {
    OpStart   = 1'b0,
    OpAdvance = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_e;

endpackage

### rtl/core/mcr_channels.sv
interface mcr_in_if import mcr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [CoordBits-1:0]  center_x;
  logic signed [CoordBits-1:0]  center_y;
  logic        [RadiusBits-1:0] radius;
  logic        [ColorBits-1:0]  color;

  modport source (output valid, op, center_x, center_y, radius, color, input ready);
  modport sink   (input valid, op, center_x, center_y, radius, color, output ready);
endinterface

interface mcr_out_if import mcr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [PixelBits-1:0] pixel_x;
  logic signed [PixelBits-1:0] pixel_y;
  logic        [ColorBits-1:0] pixel_color;
  logic                        visible;
  logic                        last_of_run;
  logic                        circle_done;

  modport source (output valid, pixel_x, pixel_y, pixel_color, visible, last_of_run,
                  circle_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, visible, last_of_run,
                  circle_done, output ready);
endinterface

### rtl/core/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer with eight-way symmetry.
// The input channel takes one transaction per command: a start (center, radius, color)
// or an advance of one iteration. Every start, and every advance while a circle is
// running, produces eight point transactions on the output channel, one per cycle,
// in the order (+x,+y) (-x,+y) (+x,-y) (-x,-y) (+y,+x) (-y,+x) (+y,-x) (-y,-x)
// while the receiver is ready. The eighth point carries last_of_run; the points of the
// iteration that ends the circle carry circle_done. An advance while no circle runs
// is taken and produces nothing.
// Each command is registered into the job register, and each point then into the
// output register. The output register sends one point per cycle while the receiver
// is ready; the next command is taken in the cycle the eighth point moves to the
// output register, so runs follow each other without gaps. The frame size lives in
// two APB registers (width at 0x0, height at 0x4). The user must write it only while
// the block is idle; the block does not enforce this. Reset clears the running circle
// and sets the frame to 1024 by 768. A stalled receiver holds the output point, which
// stalls the point sequencer and then the input channel; no point is lost.
module midpoint_circle_rasterizer import mcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  mcr_in_if.sink                 in_ch_i,
  mcr_out_if.source              out_ch_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [CfgDataBits-1:0] pwdata,
  output logic [CfgDataBits-1:0] prdata,
  output logic                   pready
);

`include "midpoint_circle_rasterizer_defines.svh"

  localparam int ExtBits = DecisionBits - CoordBits;
  localparam int VisBits = (PixelBits > FrameBits) ? PixelBits : FrameBits;

  typedef struct packed {
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
    logic signed [CoordBits-1:0] ox;
    logic signed [CoordBits-1:0] oy;
    logic        [ColorBits-1:0] color;
    logic                        done;
  } job_t;

  logic [FrameBits-1:0] frame_width_q, frame_height_q;
  reg_e                 cfg_reg;
  logic                 cfg_write;

  logic                           running_q, running_d;
  logic signed [CoordBits-1:0]    center_col_q, center_col_d;
  logic signed [CoordBits-1:0]    center_row_q, center_row_d;
  logic        [ColorBits-1:0]    draw_color_q, draw_color_d;
  logic signed [CoordBits-1:0]    offset_x_q, offset_x_d;
  logic signed [CoordBits-1:0]    offset_y_q, offset_y_d;
  logic        [DecisionBits-1:0] decision_q, decision_d;

  logic                    job_valid_q, job_valid_d;
  job_t                    job_q, job_d;
  logic [PointIdxBits-1:0] idx_q, idx_d;

  logic                        out_valid_q;
  logic signed [PixelBits-1:0] pixel_x_q, pixel_y_q;
  logic        [ColorBits-1:0] pixel_color_q;
  logic                        visible_q, last_q, done_q;

  logic                        in_fire, emit, out_load, job_last;
  logic                        dec_pos, adv_done;
  logic [DecisionBits-1:0]     x_ext, y_ext;
  logic signed [CoordBits-1:0] x_new, y_new;
  logic signed [CoordBits-1:0] sel_a, sel_b;
  logic signed [PixelBits-1:0] px, py;
  logic                        vis;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_reg   = reg_e'(paddr[CfgAddrBits-1]);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_reg)
      RegFrameWidth:  prdata = CfgDataBits'(frame_width_q);
      RegFrameHeight: prdata = CfgDataBits'(frame_height_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthReset;
      frame_height_q <= FrameHeightReset;
    end else if (cfg_write) begin
      unique case (cfg_reg)
        RegFrameWidth:  frame_width_q  <= pwdata[FrameBits-1:0];
        RegFrameHeight: frame_height_q <= pwdata[FrameBits-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control.
  assign out_load        = job_valid_q && (!out_valid_q || out_ch_o.ready);
  assign job_last        = out_load && (idx_q == PointIdxBits'(PointsPerRun - 1));
  assign in_ch_i.ready   = !job_valid_q || job_last;
  assign in_fire         = in_ch_i.valid && in_ch_i.ready;
  assign emit            = (in_ch_i.op == OpStart) || running_q;

  // One midpoint iteration.
  assign dec_pos  = !decision_q[DecisionBits-1] && (decision_q != '0);
  assign x_ext    = {{ExtBits{offset_x_q[CoordBits-1]}}, offset_x_q} + DecisionBits'(1);
  assign y_ext    = {{ExtBits{offset_y_q[CoordBits-1]}}, offset_y_q}
                    - DecisionBits'(dec_pos);
  assign x_new    = x_ext[CoordBits-1:0];
  assign y_new    = y_ext[CoordBits-1:0];
  assign adv_done = y_new < x_new;

  always_comb begin
    running_d    = running_q;
    center_col_d = center_col_q;
    center_row_d = center_row_q;
    draw_color_d = draw_color_q;
    offset_x_d   = offset_x_q;
    offset_y_d   = offset_y_q;
    decision_d   = decision_q;
    job_d        = job_q;
    if (in_fire) begin
      if (in_ch_i.op == OpStart) begin
        running_d    = 1'b1;
        center_col_d = in_ch_i.center_x;
        center_row_d = in_ch_i.center_y;
        draw_color_d = in_ch_i.color;
        offset_x_d   = '0;
        offset_y_d   = CoordBits'(in_ch_i.radius);
        decision_d   = DecisionInit - DecisionBits'({in_ch_i.radius, 1'b0});
        job_d        = '{cx: in_ch_i.center_x, cy: in_ch_i.center_y, ox: '0,
                         oy: CoordBits'(in_ch_i.radius), color: in_ch_i.color,
                         done: 1'b0};
      end else if (running_q) begin
        running_d  = !adv_done;
        offset_x_d = x_new;
        offset_y_d = y_new;
        decision_d = dec_pos ? decision_q + ((x_ext - y_ext) << 2) + StepDiag
                             : decision_q + (x_ext << 2) + StepAxis;
        job_d      = '{cx: center_col_q, cy: center_row_q, ox: x_new, oy: y_new,
                       color: draw_color_q, done: adv_done};
      end
    end
  end

  always_comb begin
    job_valid_d = job_valid_q;
    idx_d       = idx_q;
    if (out_load) begin
      idx_d = idx_q + PointIdxBits'(1);
    end
    if (job_last) begin
      job_valid_d = 1'b0;
    end
    if (in_fire && emit) begin
      job_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  // Point of the current symmetry slot: bit 2 swaps the axes, bits 0 and 1 negate.
  assign sel_a = idx_q[2] ? job_q.oy : job_q.ox;
  assign sel_b = idx_q[2] ? job_q.ox : job_q.oy;
  assign px    = idx_q[0] ? PixelBits'(job_q.cx) - PixelBits'(sel_a)
                          : PixelBits'(job_q.cx) + PixelBits'(sel_a);
  assign py    = idx_q[1] ? PixelBits'(job_q.cy) - PixelBits'(sel_b)
                          : PixelBits'(job_q.cy) + PixelBits'(sel_b);
  assign vis   = !px[PixelBits-1] && !py[PixelBits-1]
                 && (VisBits'(unsigned'(px)) < VisBits'(frame_width_q))
                 && (VisBits'(unsigned'(py)) < VisBits'(frame_height_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      center_col_q <= '0;
      center_row_q <= '0;
      draw_color_q <= '0;
      offset_x_q   <= '0;
      offset_y_q   <= '0;
      decision_q   <= '0;
      job_valid_q  <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      running_q    <= running_d;
      center_col_q <= center_col_d;
      center_row_q <= center_row_d;
      draw_color_q <= draw_color_d;
      offset_x_q   <= offset_x_d;
      offset_y_q   <= offset_y_d;
      decision_q   <= decision_d;
      job_valid_q  <= job_valid_d;
      idx_q        <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (out_load) begin
      pixel_x_q     <= px;
      pixel_y_q     <= py;
      pixel_color_q <= job_q.color;
      visible_q     <= vis;
      last_q        <= (idx_q == PointIdxBits'(PointsPerRun - 1));
      done_q        <= job_q.done;
    end
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.pixel_x     = pixel_x_q;
  assign out_ch_o.pixel_y     = pixel_y_q;
  assign out_ch_o.pixel_color = pixel_color_q;
  assign out_ch_o.visible     = visible_q;
  assign out_ch_o.last_of_run = last_q;
  assign out_ch_o.circle_done = done_q;

  `MCR_ASSERT_DEF(a_accept_only_when_free, in_fire |-> (!job_valid_q || job_last))
  `MCR_ASSERT_DEF(a_run_starts_at_first_point,
    (in_fire && emit) |=> (job_valid_q && (idx_q == '0)))
  `MCR_ASSERT_DEF(a_idle_advance_keeps_state,
    (in_fire && !emit) |=> ($stable(offset_x_q) && $stable(offset_y_q)
                            && $stable(decision_q) && !running_q))

endmodule

### dv/tb_midpoint_circle_rasterizer.sv
`timescale 1ns / 100ps

module tb_midpoint_circle_rasterizer;
  import mcr_pkg::*;

  typedef struct {
    op_e                          op;
    logic signed [CoordBits-1:0]  col;
    logic signed [CoordBits-1:0]  row;
    logic        [RadiusBits-1:0] radius;
    logic        [ColorBits-1:0]  color;
  } circle_cmd_t;

  typedef struct {
    logic signed [PixelBits-1:0] px;
    logic signed [PixelBits-1:0] py;
    logic        [ColorBits-1:0] color;
    logic                        visible;
    logic                        last;
    logic                        done;
  } pixel_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CfgAddrBits-1:0] paddr;
  logic [CfgDataBits-1:0] pwdata;
  logic [CfgDataBits-1:0] prdata;
  logic                   pready;

  mcr_in_if  cmd_ch ();
  mcr_out_if pix_ch ();

  midpoint_circle_rasterizer u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (cmd_ch),
    .out_ch_o (pix_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  circle_cmd_t pending_cmds[$];
  pixel_t      expected_pixels[$];
  circle_cmd_t cur_cmd;
  int          cmds_queued;
  int          cmds_taken;
  int          pixels_seen;
  int          fail_count;

  // Shadow of the rasterizer state and frame registers.
  logic                           drawing;
  logic signed [CoordBits-1:0]    ctr_col;
  logic signed [CoordBits-1:0]    ctr_row;
  logic        [ColorBits-1:0]    pen_color;
  logic signed [CoordBits-1:0]    off_x;
  logic signed [CoordBits-1:0]    off_y;
  logic signed [DecisionBits-1:0] err_term;
  logic        [FrameBits-1:0]    frame_cols;
  logic        [FrameBits-1:0]    frame_rows;

  int send_gap;
  bit send_calm;
  int rcv_stall;
  int rcv_gap;
  bit rcv_calm;
  int long_hold;
  bit long_hold_used;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int idle_gap(bit calm);
    if (calm) return 0;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 0;
      6, 7: return $urandom_range(3, 1);
      8: return $urandom_range(8, 4);
      default: return $urandom_range(40, 10);
    endcase
  endfunction

  task automatic push_octants(bit done);
    int cx, cy, ox, oy;
    int xs[8];
    int ys[8];
    pixel_t p;
    cx = ctr_col;
    cy = ctr_row;
    ox = off_x;
    oy = off_y;
    xs = '{cx + ox, cx - ox, cx + ox, cx - ox, cx + oy, cx - oy, cx + oy, cx - oy};
    ys = '{cy + oy, cy + oy, cy - oy, cy - oy, cy + ox, cy + ox, cy - ox, cy - ox};
    for (int k = 0; k < PointsPerRun; k++) begin
      p.px      = PixelBits'(xs[k]);
      p.py      = PixelBits'(ys[k]);
      p.color   = pen_color;
      p.visible = xs[k] >= 0 && ys[k] >= 0 && xs[k] < int'(frame_cols) &&
                  ys[k] < int'(frame_rows);
      p.last    = (k == PointsPerRun - 1);
      p.done    = done;
      expected_pixels = {expected_pixels, p};
    end
  endtask

  task automatic rasterize(circle_cmd_t c);
    int nx, ny, nd;
    if (c.op == OpStart) begin
      ctr_col   = c.col;
      ctr_row   = c.row;
      pen_color = c.color;
      off_x     = '0;
      off_y     = $signed({1'b0, c.radius});
      err_term  = DecisionBits'(int'(DecisionInit) - 2 * int'(c.radius));
      drawing   = 1'b1;
      push_octants(1'b0);
    end else if (drawing) begin
      nx = int'(off_x) + 1;
      ny = off_y;
      nd = err_term;
      if (nd > 0) begin
        ny = ny - 1;
        nd = nd + 4 * (nx - ny) + int'(StepDiag);
      end else begin
        nd = nd + 4 * nx + int'(StepAxis);
      end
      off_x    = CoordBits'(nx);
      off_y    = CoordBits'(ny);
      err_term = DecisionBits'(nd);
      drawing  = !(off_y < off_x);
      push_octants(!drawing);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        rasterize(cur_cmd);
        cmds_taken++;
        send_gap = idle_gap(send_calm);
        if ($urandom_range(39) == 0) send_calm = !send_calm;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (send_gap > 0) begin
          cmd_ch.valid <= 1'b0;
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          cmd_ch.valid    <= 1'b1;
          cmd_ch.op       <= cur_cmd.op;
          cmd_ch.center_x <= cur_cmd.col;
          cmd_ch.center_y <= cur_cmd.row;
          cmd_ch.radius   <= cur_cmd.radius;
          cmd_ch.color    <= cur_cmd.color;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_pixel();
    pixel_t e;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel transaction at (%0d, %0d)", pix_ch.pixel_x, pix_ch.pixel_y);
      fail_count++;
      return;
    end
    e = expected_pixels.pop_front();
    if (pix_ch.pixel_x !== e.px) begin
      $error("pixel_x: expected %0d, got %0d", e.px, pix_ch.pixel_x);
      fail_count++;
    end
    if (pix_ch.pixel_y !== e.py) begin
      $error("pixel_y: expected %0d, got %0d", e.py, pix_ch.pixel_y);
      fail_count++;
    end
    if (pix_ch.pixel_color !== e.color) begin
      $error("pixel_color: expected %h, got %h", e.color, pix_ch.pixel_color);
      fail_count++;
    end
    if (pix_ch.visible !== e.visible) begin
      $error("visible: expected %0b, got %0b", e.visible, pix_ch.visible);
      fail_count++;
    end
    if (pix_ch.last_of_run !== e.last) begin
      $error("last_of_run: expected %0b, got %0b", e.last, pix_ch.last_of_run);
      fail_count++;
    end
    if (pix_ch.circle_done !== e.done) begin
      $error("circle_done: expected %0b, got %0b", e.done, pix_ch.circle_done);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_ch.valid && pix_ch.ready) begin
        check_pixel();
        pixels_seen++;
        if ($urandom_range(49) == 0) rcv_calm = !rcv_calm;
      end
      if (long_hold > 0) begin
        pix_ch.ready <= 1'b0;
        long_hold--;
      end else if (!long_hold_used && pixels_seen >= 200) begin
        // Hold the receiver long enough for the input channel to back up.
        pix_ch.ready <= 1'b0;
        long_hold      = 150;
        long_hold_used = 1'b1;
      end else if (rcv_stall > 0) begin
        pix_ch.ready <= 1'b0;
        rcv_stall--;
      end else if (pix_ch.valid && pix_ch.ready) begin
        rcv_gap = idle_gap(rcv_calm);
        pix_ch.ready <= (rcv_gap == 0);
        rcv_stall = (rcv_gap > 0) ? rcv_gap - 1 : 0;
      end else begin
        pix_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_frame(reg_e r, int value);
    logic [FrameBits-1:0] written;
    written = FrameBits'(value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= CfgDataBits'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (r == RegFrameWidth) frame_cols = written;
    else frame_rows = written;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== CfgDataBits'(written)) begin
      $error("prdata: expected %0d, got %0d", written, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_cmd(op_e op, int col, int row, int rad, logic [ColorBits-1:0] color);
    circle_cmd_t c;
    c.op     = op;
    c.col    = CoordBits'(col);
    c.row    = CoordBits'(row);
    c.radius = RadiusBits'(rad);
    c.color  = color;
    pending_cmds = {pending_cmds, c};
    cmds_queued++;
  endtask

  task automatic queue_advance();
    queue_cmd(OpAdvance, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic queue_random_circles(int n_items);
    int used, rad, col, row, need, adv, useful;
    used = 0;
    while (used < n_items) begin
      case ($urandom_range(19))
        0: rad = $urandom_range(4095);
        1, 2, 3: rad = $urandom_range(300);
        default: rad = $urandom_range(24);
      endcase
      if ($urandom_range(1)) begin
        col = int'($urandom_range(8191)) - 4096;
        row = int'($urandom_range(8191)) - 4096;
      end else begin
        col = int'($urandom_range(1100)) - 40;
        row = int'($urandom_range(840)) - 40;
      end
      queue_cmd(OpStart, col, row, rad, $urandom);
      need = rad * 3 / 4 + 2;
      adv  = need;
      if ($urandom_range(4) == 0) adv = $urandom_range(need);
      if (adv > 40) adv = $urandom_range(40);
      for (int k = 0; k < adv; k++) queue_advance();
      useful = rad * 7 / 10 + 1;
      used += 1 + ((adv < useful) ? adv : useful);
    end
  endtask

  task automatic wait_idle();
    while (cmds_taken != cmds_queued || expected_pixels.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.op       = OpStart;
    cmd_ch.center_x = '0;
    cmd_ch.center_y = '0;
    cmd_ch.radius   = '0;
    cmd_ch.color    = '0;
    pix_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    cmds_queued     = 0;
    cmds_taken      = 0;
    pixels_seen     = 0;
    fail_count      = 0;
    send_gap        = 0;
    send_calm       = 1'b0;
    rcv_stall       = 0;
    rcv_calm        = 1'b0;
    long_hold       = 0;
    long_hold_used  = 1'b0;
    drawing         = 1'b0;
    ctr_col         = '0;
    ctr_row         = '0;
    pen_color       = '0;
    off_x           = '0;
    off_y           = '0;
    err_term        = '0;
    frame_cols      = FrameWidthReset;
    frame_rows      = FrameHeightReset;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_frame(RegFrameWidth, 640);
    write_frame(RegFrameHeight, 480);
    queue_advance();
    queue_cmd(OpStart, 100, 100, 0, 32'h0000_0000);
    queue_advance();
    queue_advance();
    queue_cmd(OpStart, -4096, -4096, 4095, 32'hFFFF_FFFF);
    queue_advance();
    queue_advance();
    queue_cmd(OpStart, 4095, 4095, 4095, 32'h1234_5678);
    queue_advance();
    queue_cmd(OpStart, 320, 240, 3, 32'hA5A5_A5A5);
    repeat (4) queue_advance();
    queue_cmd(OpStart, 0, 0, 1, 32'h5A5A_5A5A);
    repeat (2) queue_advance();
    queue_cmd(OpStart, 639, 479, 2, 32'h8000_0001);
    repeat (3) queue_advance();
    queue_cmd(OpStart, -2, 481, 5, 32'hDEAD_BEEF);
    queue_advance();
    wait_idle();

    write_frame(RegFrameWidth, 1024);
    write_frame(RegFrameHeight, 768);
    queue_random_circles(25);
    wait_idle();

    write_frame(RegFrameWidth, 0);
    write_frame(RegFrameHeight, 0);
    queue_random_circles(6);
    wait_idle();

    write_frame(RegFrameWidth, 8191);
    write_frame(RegFrameHeight, 8191);
    queue_random_circles(8);
    wait_idle();

    write_frame(RegFrameWidth, 1);
    write_frame(RegFrameHeight, 1);
    queue_cmd(OpStart, 0, 0, 0, $urandom);
    queue_random_circles(6);
    wait_idle();

    write_frame(RegFrameWidth, 4096);
    write_frame(RegFrameHeight, 4096);
    queue_random_circles(10);
    wait_idle();

    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixel transactions never arrived", expected_pixels.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/mcr_pkg.sv
rtl/core/mcr_channels.sv
rtl/core/midpoint_circle_rasterizer.sv
dv/tb_midpoint_circle_rasterizer.sv
